>>> rtl/tte_pkg.sv
// shared constants, codes and control types of the tap tempo estimator
package tte_pkg;

  // default depth of the interval history
  localparam int TAP_HISTORY_DEF = 4;

  // field widths
  localparam int TIME_W     = 32;
  localparam int REQ_W      = 16;
  localparam int BPM_W      = 10;
  localparam int PERIOD_W   = 22;
  localparam int GAP_W      = 12;
  localparam int TMO_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // shared divider widths
  localparam int DIVD_W = 26;
  localparam int DIVS_W = 16;

  // reset values
  localparam logic [BPM_W-1:0] TEMPO_RESET    = 10'd120;
  localparam logic [BPM_W-1:0] BPM_LOW_RESET  = 10'd30;
  localparam logic [BPM_W-1:0] BPM_HIGH_RESET = 10'd300;
  localparam logic [TMO_W-1:0] TMO_RESET      = 16'd2500;
  localparam logic [GAP_W-1:0] MIN_RESET      = 12'd200;
  localparam logic [GAP_W-1:0] MAX_RESET      = 12'd2000;

  // time constants
  localparam logic [DIVD_W-1:0] MS_PER_MINUTE = 26'd60000;
  localparam logic [DIVD_W-1:0] US_PER_MINUTE = 26'd60000000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPM_LOW     = 3'd0,
    REG_BPM_HIGH    = 3'd1,
    REG_TAP_TIMEOUT = 3'd2,
    REG_TAP_MIN     = 3'd3,
    REG_TAP_MAX     = 3'd4
  } cfg_reg_t;

  // divider operand select
  typedef enum logic [1:0] {
    DIV_AVG   = 2'd0,
    DIV_TEMPO = 2'd1,
    DIV_CLK   = 2'd2
  } div_sel_t;

  // classification of a tap gap
  typedef enum logic [1:0] {
    GAP_ACCEPT  = 2'd0,
    GAP_RESTART = 2'd1,
    GAP_IGNORE  = 2'd2
  } gap_class_t;

  // controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     set_tempo;
    logic     tap_eval;
    logic     sum_step;
    logic     div_start;
    div_sel_t div_sel;
    logic     avg_take;
    logic     tempo_take;
    logic     load_out;
  } tte_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       func;
    gap_class_t gap_class;
    logic       sum_last;
    logic       div_busy;
    logic       div_done;
    logic       avg_zero;
  } tte_sts_t;

endpackage

>>> rtl/tte_if.sv
// handshake channels of the tap tempo estimator: input, result and configuration

interface tte_in_if;
  import tte_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [TIME_W-1:0] tap_time_ms;
  logic [REQ_W-1:0]  tempo_request;
  modport source(output valid, func, tap_time_ms, tempo_request, input ready);
  modport sink(input valid, func, tap_time_ms, tempo_request, output ready);
endinterface

interface tte_out_if;
  import tte_pkg::*;
  logic                valid;
  logic                ready;
  logic [BPM_W-1:0]    tempo_bpm;
  logic [PERIOD_W-1:0] clock_period_us;
  modport source(output valid, tempo_bpm, clock_period_us, input ready);
  modport sink(input valid, tempo_bpm, clock_period_us, output ready);
endinterface

interface tte_cfg_if;
  import tte_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/tap_tempo_estimator_unit.sv
// top level of the tap tempo estimator
// a tempo setting, a restart or an ignored tap goes straight to the clock-period division; an accepted tap
//   first sums the held intervals (up to TAP_HISTORY), then divides for the average and, unless it is zero, the tempo
// one word is processed at a time; the shared 26-step divider sets the pace
// reset: synchronous rst_n; tempo 120, limits and tap windows at defaults, history empty
module tap_tempo_estimator_unit #(
  parameter int TAP_HISTORY = tte_pkg::TAP_HISTORY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tte_in_if.sink    in_ch,
  tte_out_if.source out_ch,
  tte_cfg_if.sink   cfg_ch
);
  import tte_pkg::*;

  tte_cmd_t cmd;
  tte_sts_t sts;

  // the user must write configuration only while idle; the block itself does not enforce it
  assign cfg_ch.ready = 1'b1;

  tte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tte_dp #(
    .TAP_HISTORY (TAP_HISTORY)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_ch.func),
    .in_tap_time_ms      (in_ch.tap_time_ms),
    .in_tempo_request    (in_ch.tempo_request),
    .cfg_we              (cfg_ch.valid && cfg_ch.ready),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .out_tempo_bpm       (out_ch.tempo_bpm),
    .out_clock_period_us (out_ch.clock_period_us)
  );

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a word is in flight");

  // divider never restarted mid-division
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // result register never overwritten before it is taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result word overwritten");

  // divider done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |=> !sts.div_done)
    else $error("divider done held longer than one cycle");

endmodule

>>> rtl/tte_div.sv
// shared restoring divider, one quotient bit per cycle
module tte_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tte_pkg::DIVD_W-1:0]   dividend,
  input  logic [tte_pkg::DIVS_W-1:0]   divisor,
  output logic [tte_pkg::DIVD_W-1:0]   quotient,
  output logic                         busy,
  output logic                         done
);
  import tte_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W:0]   diff;
  logic              ge;

  // trial subtraction of one step
  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  // step sequencing
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign busy     = busy_r;
  assign done     = done_r;

endmodule

>>> rtl/tte_dp.sv
// datapath: config registers, tap history, ring sum, shared divider and result register
module tte_dp #(
  parameter int TAP_HISTORY = tte_pkg::TAP_HISTORY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tte_pkg::tte_cmd_t               cmd,
  output tte_pkg::tte_sts_t               sts,
  input  logic                            in_func,
  input  logic [tte_pkg::TIME_W-1:0]      in_tap_time_ms,
  input  logic [tte_pkg::REQ_W-1:0]       in_tempo_request,
  input  logic                            cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [tte_pkg::BPM_W-1:0]       out_tempo_bpm,
  output logic [tte_pkg::PERIOD_W-1:0]    out_clock_period_us
);
  import tte_pkg::*;

  localparam int FILL_W = $clog2(TAP_HISTORY + 1);
  localparam int SLOT_W = (TAP_HISTORY > 1) ? $clog2(TAP_HISTORY) : 1;
  localparam int SUM_W  = GAP_W + $clog2(TAP_HISTORY);

  // configuration
  logic [BPM_W-1:0]  bpm_low_r, bpm_high_r;
  logic [TMO_W-1:0]  timeout_r;
  logic [GAP_W-1:0]  min_r, max_r;

  // captured word
  logic              func_r;
  logic [TIME_W-1:0] time_r;
  logic [REQ_W-1:0]  req_r;

  // estimator state
  logic [TIME_W-1:0] prev_r;
  logic [GAP_W-1:0]  ring_r [TAP_HISTORY];
  logic [FILL_W-1:0] fill_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] idx_r;
  logic [SUM_W-1:0]  sum_r;
  logic [GAP_W-1:0]  avg_r;
  logic [BPM_W-1:0]  tempo_r;
  logic              shown_zero_r;

  // result register
  logic [BPM_W-1:0]    res_tempo_r;
  logic [PERIOD_W-1:0] res_period_r;

  logic [TIME_W-1:0] gap;
  gap_class_t        gap_class;
  logic [BPM_W-1:0]  bpm_eff;
  logic [DIVD_W-1:0] div_dvd;
  logic [DIVS_W-1:0] div_dvs;
  logic [DIVD_W-1:0] div_quo;
  logic              div_busy;
  logic              div_done;

  // clamp a tempo into the configured limits, low first
  function automatic logic [BPM_W-1:0] clamp_bpm(input logic [DIVD_W-1:0] t,
                                                 input logic [BPM_W-1:0] lo,
                                                 input logic [BPM_W-1:0] hi);
    logic [DIVD_W-1:0] v;
    v = t;
    if (v < DIVD_W'(lo)) v = DIVD_W'(lo);
    if (v > DIVD_W'(hi)) v = DIVD_W'(hi);
    return v[BPM_W-1:0];
  endfunction

  // gap to the previous tap and its class
  assign gap = time_r - prev_r;

  always_comb begin
    if (gap > TIME_W'(timeout_r)) begin
      gap_class = GAP_RESTART;
    end else if (gap < TIME_W'(min_r) || gap > TIME_W'(max_r)) begin
      gap_class = GAP_IGNORE;
    end else begin
      gap_class = GAP_ACCEPT;
    end
  end

  // a stored tempo of zero times the clock as the reset tempo
  assign bpm_eff = (tempo_r == '0) ? TEMPO_RESET : tempo_r;

  // divider operand select
  always_comb begin
    case (cmd.div_sel)
      DIV_AVG: begin
        div_dvd = DIVD_W'(sum_r);
        div_dvs = DIVS_W'(fill_r);
      end
      DIV_TEMPO: begin
        div_dvd = MS_PER_MINUTE + DIVD_W'(avg_r >> 1);
        div_dvs = DIVS_W'(avg_r);
      end
      DIV_CLK: begin
        div_dvd = US_PER_MINUTE;
        div_dvs = DIVS_W'({bpm_eff, 4'b0000}) + DIVS_W'({bpm_eff, 3'b000});
      end
      default: begin
        div_dvd = '0;
        div_dvs = DIVS_W'(1);
      end
    endcase
  end

  tte_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .busy     (div_busy),
    .done     (div_done)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpm_low_r  <= BPM_LOW_RESET;
      bpm_high_r <= BPM_HIGH_RESET;
      timeout_r  <= TMO_RESET;
      min_r      <= MIN_RESET;
      max_r      <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BPM_LOW:     bpm_low_r  <= cfg_data[BPM_W-1:0];
        REG_BPM_HIGH:    bpm_high_r <= cfg_data[BPM_W-1:0];
        REG_TAP_TIMEOUT: timeout_r  <= cfg_data[TMO_W-1:0];
        REG_TAP_MIN:     min_r      <= cfg_data[GAP_W-1:0];
        REG_TAP_MAX:     max_r      <= cfg_data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // tap history and tempo state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      fill_r       <= '0;
      slot_r       <= '0;
      tempo_r      <= TEMPO_RESET;
      shown_zero_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        shown_zero_r <= 1'b0;
      end
      if (cmd.set_tempo) begin
        tempo_r <= clamp_bpm(DIVD_W'(req_r), bpm_low_r, bpm_high_r);
      end
      if (cmd.tap_eval) begin
        prev_r <= time_r;
        case (gap_class)
          GAP_RESTART: begin
            fill_r       <= '0;
            slot_r       <= '0;
            shown_zero_r <= 1'b1;
          end
          GAP_ACCEPT: begin
            slot_r <= (slot_r == SLOT_W'(TAP_HISTORY - 1)) ? '0 : slot_r + SLOT_W'(1);
            if (fill_r < FILL_W'(TAP_HISTORY)) fill_r <= fill_r + FILL_W'(1);
          end
          default: begin
          end
        endcase
      end
      if (cmd.tempo_take) begin
        tempo_r <= clamp_bpm(div_quo, bpm_low_r, bpm_high_r);
      end
    end
  end

  // captured word, ring entries and working values
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      time_r <= in_tap_time_ms;
      req_r  <= in_tempo_request;
    end
    if (cmd.tap_eval) begin
      sum_r <= '0;
      idx_r <= '0;
      if (gap_class == GAP_ACCEPT) ring_r[slot_r] <= gap[GAP_W-1:0];
    end
    if (cmd.sum_step) begin
      sum_r <= sum_r + SUM_W'(ring_r[idx_r]);
      idx_r <= idx_r + SLOT_W'(1);
    end
    if (cmd.avg_take) begin
      avg_r <= div_quo[GAP_W-1:0];
    end
    if (cmd.load_out) begin
      res_tempo_r  <= shown_zero_r ? '0 : tempo_r;
      res_period_r <= div_quo[PERIOD_W-1:0];
    end
  end

  // status to the controller
  always_comb begin
    sts.func      = func_r;
    sts.gap_class = gap_class;
    sts.sum_last  = (FILL_W'(idx_r) == fill_r - FILL_W'(1));
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.avg_zero  = (avg_r == '0);
  end

  assign out_tempo_bpm       = res_tempo_r;
  assign out_clock_period_us = res_period_r;

endmodule

>>> rtl/tte_ctrl.sv
// controller: sequences capture, ring sum, up to three divisions and the result word
module tte_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tte_pkg::tte_cmd_t  cmd,
  input  tte_pkg::tte_sts_t  sts
);
  import tte_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_TEMPO_GO,
    ST_TEMPO_WAIT,
    ST_CLK_GO,
    ST_CLK_WAIT,
    ST_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new word
  assign out_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.div_sel   = DIV_AVG;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.func) begin
          cmd.set_tempo = 1'b1;
          state_nxt     = ST_CLK_GO;
        end else begin
          cmd.tap_eval = 1'b1;
          state_nxt    = (sts.gap_class == GAP_ACCEPT) ? ST_SUM : ST_CLK_GO;
        end
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) state_nxt = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AVG;
        state_nxt     = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (sts.div_done) begin
          cmd.avg_take = 1'b1;
          state_nxt    = ST_TEMPO_GO;
        end
      end
      ST_TEMPO_GO: begin
        // a zero average leaves the tempo as it is
        if (sts.avg_zero) begin
          state_nxt = ST_CLK_GO;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_TEMPO;
          state_nxt     = ST_TEMPO_WAIT;
        end
      end
      ST_TEMPO_WAIT: begin
        cmd.div_sel = DIV_TEMPO;
        if (sts.div_done) begin
          cmd.tempo_take = 1'b1;
          state_nxt      = ST_CLK_GO;
        end
      end
      ST_CLK_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CLK;
        state_nxt     = ST_CLK_WAIT;
      end
      ST_CLK_WAIT: begin
        cmd.div_sel = DIV_CLK;
        if (sts.div_done) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
